// ===== hw/rtl/lltx_pkg.sv =====
// lltx_pkg: shared types, constants and codes of the log line timestamp extractor
// no dependencies; used by lltx_front, lltx_back, the top level and the testbench

package lltx_pkg;

    localparam int MAX_ELEMENTS  = 64;
    localparam int LITERAL_DEPTH = 1024;
    localparam int EIDX_W        = $clog2(MAX_ELEMENTS);
    localparam int ETOT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int LADDR_W       = $clog2(LITERAL_DEPTH);
    localparam int LTOT_W        = $clog2(LITERAL_DEPTH + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int TPOS_W        = 4;

    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_FMT   = 2'd1,
        ACT_END   = 2'd2,
        ACT_LOG   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_TIME    = 2'd2,
        KIND_EOL     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_COPY = 2'd0,
        PH_LIT  = 2'd1,
        PH_TIME = 2'd2,
        PH_WAIT = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BS_RUN,
        BS_REQ_E,
        BS_CAP_E,
        BS_CAP_L
    } t_bstate;

    typedef struct packed {
        t_action    action;
        logic [7:0] ch;
        logic       is_break;
        logic       is_skip;
    } t_cmd;

    typedef struct packed {
        logic [7:0]         ch;
        logic [LADDR_W-1:0] first;
        logic [LADDR_W-1:0] last;
    } t_elem;

    localparam int ELEM_W = $bits(t_elem);

endpackage

// ===== hw/rtl/lltx_in_if.sv =====
// lltx_in_if: input channel of the extractor, valid/ready plus one word
// no dependencies

interface lltx_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_in;

    modport source(output valid, output action, output char_in, input ready);
    modport sink(input valid, input action, input char_in, output ready);
endinterface

// ===== hw/rtl/lltx_out_if.sv =====
// lltx_out_if: result channel of the extractor, valid/ready plus one word
// no dependencies

interface lltx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [9:0] millis;
    logic       format_overflow;

    modport source(output valid, output kind, output payload, output hours, output minutes,
                   output seconds, output millis, output format_overflow, input ready);
    modport sink(input valid, input kind, input payload, input hours, input minutes,
                 input seconds, input millis, input format_overflow, output ready);
endinterface

// ===== hw/rtl/lltx_ram.sv =====
// lltx_ram: generic single write port ram with registered read
// no dependencies

module lltx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/lltx_front.sv =====
// lltx_front: takes input words, classifies the character and queues the command
// depends on lltx_pkg and lltx_in_if

module lltx_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lltx_in_if.sink           i_in,
    input  logic              i_pop,
    output logic              o_valid,
    output lltx_pkg::t_cmd    o_cmd
);
    lltx_pkg::t_cmd                r_mem [lltx_pkg::QUEUE_DEPTH];
    logic [lltx_pkg::QPTR_W-1:0]   r_wp;
    logic [lltx_pkg::QPTR_W-1:0]   r_rp;
    logic [lltx_pkg::QPTR_W:0]     r_cnt;
    lltx_pkg::t_cmd                cmd;
    logic                          push;

    always_comb begin
        cmd.action   = lltx_pkg::t_action'(i_in.action);
        cmd.ch       = i_in.char_in;
        cmd.is_break = (i_in.char_in == lltx_pkg::CH_CR) || (i_in.char_in == lltx_pkg::CH_LF);
        cmd.is_skip  = (i_in.char_in inside {[8'h61:8'h7a], [8'h30:8'h39]})
                     || (i_in.char_in == lltx_pkg::CH_SPACE)
                     || ((i_in.char_in inside {[8'h41:8'h5a]})
                         && (i_in.char_in != lltx_pkg::CH_T));
    end

    assign i_in.ready = (r_cnt != (lltx_pkg::QPTR_W + 1)'(lltx_pkg::QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_valid    = (r_cnt != '0);
    assign o_cmd      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (lltx_pkg::QPTR_W + 1)'(push) - (lltx_pkg::QPTR_W + 1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (lltx_pkg::QPTR_W + 1)'(lltx_pkg::QUEUE_DEPTH)) else $error("queue count");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1)) else $error("queue count step");
`endif
endmodule

// ===== hw/rtl/lltx_back.sv =====
// lltx_back: compiles the pattern and matches log bytes, with element and literal stores
// depends on lltx_pkg, lltx_ram and lltx_out_if

module lltx_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_valid,
    input  lltx_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    lltx_out_if.source        o_out
);
    lltx_pkg::t_bstate               r_state, n_state;
    lltx_pkg::t_phase                r_phase, n_phase;
    logic [lltx_pkg::ETOT_W-1:0]     r_etotal, n_etotal;
    logic [lltx_pkg::LTOT_W-1:0]     r_ltotal, n_ltotal;
    logic [lltx_pkg::LTOT_W-1:0]     r_qbegin, n_qbegin;
    logic                            r_inq, n_inq;
    logic                            r_ovf, n_ovf;
    logic                            r_haspay, n_haspay;
    logic [lltx_pkg::ETOT_W-1:0]     r_eidx, n_eidx;
    logic [lltx_pkg::LADDR_W-1:0]    r_loff, n_loff;
    logic [lltx_pkg::TPOS_W-1:0]     r_tpos, n_tpos;
    logic [6:0]                      r_hour, n_hour, r_min, n_min, r_sec, n_sec;
    logic [9:0]                      r_milli, n_milli;
    lltx_pkg::t_elem                 r_cur, n_cur;
    logic [7:0]                      r_lit, n_lit;
    logic                            r_mode;

    logic                            r_ov;
    lltx_pkg::t_kind                 r_kind, n_kind;
    logic [7:0]                      r_pay, n_pay;
    logic [6:0]                      r_oh, r_om, r_os;
    logic [9:0]                      r_oms, n_oms;

    logic                            take, out_free, enter, add_req, tdone, dig;
    logic [7:0]                      add_ch;
    logic [lltx_pkg::LADDR_W-1:0]    add_first, add_last, at;
    logic [lltx_pkg::LTOT_W-1:0]     ltot_m1;
    logic [3:0]                      d;

    logic                            elem_we, lit_we;
    lltx_pkg::t_elem                 elem_wd, elem_rd;
    logic [lltx_pkg::ELEM_W-1:0]     elem_rbits;
    logic [lltx_pkg::LADDR_W-1:0]    lit_ra;
    logic [7:0]                      lit_rd;

    lltx_ram #(.WIDTH(lltx_pkg::ELEM_W), .DEPTH(lltx_pkg::MAX_ELEMENTS)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (elem_we),
        .i_waddr (r_etotal[lltx_pkg::EIDX_W-1:0]),
        .i_wdata (elem_wd),
        .i_raddr (r_eidx[lltx_pkg::EIDX_W-1:0]),
        .o_rdata (elem_rbits)
    );
    assign elem_rd = lltx_pkg::t_elem'(elem_rbits);

    lltx_ram #(.WIDTH(8), .DEPTH(lltx_pkg::LITERAL_DEPTH)) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (lit_we),
        .i_waddr (r_ltotal[lltx_pkg::LADDR_W-1:0]),
        .i_wdata (i_cmd.ch),
        .i_raddr (lit_ra),
        .o_rdata (lit_rd)
    );

    assign out_free = !r_ov || o_out.ready;
    assign take     = (r_state == lltx_pkg::BS_RUN) && i_valid && out_free;
    assign o_pop    = take;

    always_comb begin
        n_state  = r_state;   n_phase  = r_phase;   n_etotal = r_etotal;
        n_ltotal = r_ltotal;  n_qbegin = r_qbegin;  n_inq    = r_inq;
        n_ovf    = r_ovf;     n_haspay = r_haspay;  n_eidx   = r_eidx;
        n_loff   = r_loff;    n_tpos   = r_tpos;    n_hour   = r_hour;
        n_min    = r_min;     n_sec    = r_sec;     n_milli  = r_milli;
        n_cur    = r_cur;     n_lit    = r_lit;
        n_kind   = lltx_pkg::KIND_NONE;
        n_pay    = '0;
        n_oms    = '0;
        enter    = 1'b0;
        add_req  = 1'b0;
        add_ch   = i_cmd.ch;
        add_first = '0;
        add_last  = '0;
        tdone    = 1'b0;
        lit_we   = 1'b0;
        elem_we  = 1'b0;
        ltot_m1  = r_ltotal - 1'b1;
        at       = r_cur.first + r_loff;
        lit_ra   = at;
        dig      = i_cmd.ch inside {[8'h30:8'h39]};
        d        = dig ? i_cmd.ch[3:0] : 4'd0;

        case (r_state)
            lltx_pkg::BS_REQ_E: begin
                n_state = lltx_pkg::BS_CAP_E;
            end
            lltx_pkg::BS_CAP_E: begin
                n_cur = elem_rd;
                if (elem_rd.ch == lltx_pkg::CH_QUOTE) begin
                    n_phase = lltx_pkg::PH_LIT;
                    n_loff  = '0;
                    lit_ra  = elem_rd.first;
                    n_state = lltx_pkg::BS_CAP_L;
                end else if (elem_rd.ch == lltx_pkg::CH_T) begin
                    n_phase = lltx_pkg::PH_TIME;
                    n_tpos  = '0;
                    n_hour  = '0; n_min = '0; n_sec = '0; n_milli = '0;
                    n_state = lltx_pkg::BS_RUN;
                end else begin
                    n_phase = lltx_pkg::PH_WAIT;
                    n_state = lltx_pkg::BS_RUN;
                end
            end
            lltx_pkg::BS_CAP_L: begin
                n_lit   = lit_rd;
                n_state = lltx_pkg::BS_RUN;
            end
            lltx_pkg::BS_RUN: begin
                if (take) begin
                    case (i_cmd.action)
                        lltx_pkg::ACT_CLEAR: begin
                            n_etotal = '0; n_ltotal = '0; n_qbegin = '0;
                            n_inq = 1'b0; n_ovf = 1'b0; n_phase = lltx_pkg::PH_COPY;
                            n_eidx = '0; n_haspay = 1'b0;
                        end
                        lltx_pkg::ACT_FMT: begin
                            if (r_inq) begin
                                if (i_cmd.ch == lltx_pkg::CH_QUOTE) begin
                                    n_inq = 1'b0;
                                    if (r_ltotal > r_qbegin) begin
                                        add_req   = 1'b1;
                                        add_ch    = lltx_pkg::CH_QUOTE;
                                        add_first = r_qbegin[lltx_pkg::LADDR_W-1:0];
                                        add_last  = ltot_m1[lltx_pkg::LADDR_W-1:0];
                                    end
                                end else if (r_ltotal >= lltx_pkg::LTOT_W'(lltx_pkg::LITERAL_DEPTH))
                                begin
                                    n_ovf = 1'b1;
                                end else begin
                                    lit_we   = 1'b1;
                                    n_ltotal = r_ltotal + 1'b1;
                                end
                            end else if (i_cmd.ch == lltx_pkg::CH_QUOTE) begin
                                n_inq    = 1'b1;
                                n_qbegin = r_ltotal;
                            end else if (!i_cmd.is_skip) begin
                                add_req = 1'b1;
                            end
                        end
                        lltx_pkg::ACT_END: begin
                            if (r_inq) begin
                                n_inq = 1'b0;
                                if (r_ltotal > r_qbegin) begin
                                    add_req   = 1'b1;
                                    add_ch    = lltx_pkg::CH_QUOTE;
                                    add_first = r_qbegin[lltx_pkg::LADDR_W-1:0];
                                    add_last  = ltot_m1[lltx_pkg::LADDR_W-1:0];
                                end
                            end
                            n_eidx   = '0;
                            enter    = 1'b1;
                            n_haspay = 1'b0;
                        end
                        lltx_pkg::ACT_LOG: begin
                            if (i_cmd.is_break) begin
                                if (r_haspay) begin
                                    n_kind = lltx_pkg::KIND_EOL;
                                end
                                n_haspay = 1'b0;
                                n_eidx   = '0;
                                enter    = 1'b1;
                            end else begin
                                case (r_phase)
                                    lltx_pkg::PH_COPY: begin
                                        n_kind   = lltx_pkg::KIND_PAYLOAD;
                                        n_pay    = i_cmd.ch;
                                        n_haspay = 1'b1;
                                    end
                                    lltx_pkg::PH_WAIT: begin
                                        if (i_cmd.ch == r_cur.ch) begin
                                            n_eidx = r_eidx + 1'b1;
                                            enter  = 1'b1;
                                        end
                                    end
                                    lltx_pkg::PH_LIT: begin
                                        if (i_cmd.ch == r_lit) begin
                                            if (at >= r_cur.last) begin
                                                n_eidx = r_eidx + 1'b1;
                                                enter  = 1'b1;
                                            end else begin
                                                n_loff  = r_loff + 1'b1;
                                                lit_ra  = at + 1'b1;
                                                n_state = lltx_pkg::BS_CAP_L;
                                            end
                                        end else begin
                                            n_loff = '0;
                                            if (r_loff != '0) begin
                                                lit_ra  = r_cur.first;
                                                n_state = lltx_pkg::BS_CAP_L;
                                            end
                                        end
                                    end
                                    lltx_pkg::PH_TIME: begin
                                        if (r_tpos == 4'd2 || r_tpos == 4'd5) begin
                                            n_tpos = (i_cmd.ch == lltx_pkg::CH_COLON)
                                                   ? r_tpos + 1'b1 : 4'd0;
                                        end else if (r_tpos == 4'd8) begin
                                            n_tpos = (i_cmd.ch == lltx_pkg::CH_DOT) ? 4'd9 : 4'd0;
                                        end else if (r_tpos > 4'd11 || !dig) begin
                                            n_tpos = '0;
                                        end else begin
                                            n_tpos = r_tpos + 1'b1;
                                            case (r_tpos)
                                                4'd0: n_hour = 7'(d);
                                                4'd1: n_hour = (r_hour << 3) + (r_hour << 1) + 7'(d);
                                                4'd3: n_min = 7'(d);
                                                4'd4: n_min = (r_min << 3) + (r_min << 1) + 7'(d);
                                                4'd6: n_sec = 7'(d);
                                                4'd7: begin
                                                    n_sec  = (r_sec << 3) + (r_sec << 1) + 7'(d);
                                                    n_tpos = 4'd8;
                                                    tdone  = !r_mode;
                                                end
                                                4'd9:  n_milli = 10'(d);
                                                4'd10: n_milli = (r_milli << 3) + (r_milli << 1)
                                                               + 10'(d);
                                                default: begin
                                                    n_milli = (r_milli << 3) + (r_milli << 1)
                                                            + 10'(d);
                                                    n_tpos  = '0;
                                                    tdone   = 1'b1;
                                                end
                                            endcase
                                        end
                                        if (tdone) begin
                                            n_kind = lltx_pkg::KIND_TIME;
                                            n_oms  = r_mode ? n_milli : 10'd0;
                                            n_eidx = r_eidx + 1'b1;
                                            enter  = 1'b1;
                                        end
                                    end
                                    default: begin
                                        n_phase = lltx_pkg::PH_COPY;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase

                    if (add_req) begin
                        if (r_etotal >= lltx_pkg::ETOT_W'(lltx_pkg::MAX_ELEMENTS)) begin
                            n_ovf = 1'b1;
                        end else begin
                            elem_we  = 1'b1;
                            n_etotal = r_etotal + 1'b1;
                        end
                    end

                    // element fetch passes through BS_REQ_E so a just written entry is seen
                    if (enter) begin
                        if (n_eidx >= n_etotal) begin
                            n_phase = lltx_pkg::PH_COPY;
                            n_eidx  = '0;
                        end else begin
                            n_state = lltx_pkg::BS_REQ_E;
                        end
                    end
                end
            end
            default: begin
                n_state = lltx_pkg::BS_RUN;
            end
        endcase

        elem_wd.ch    = add_ch;
        elem_wd.first = add_first;
        elem_wd.last  = add_last;
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_lit   <= n_lit;
        if (take) begin
            r_kind <= n_kind;
            r_pay  <= n_pay;
            r_oh   <= (n_kind == lltx_pkg::KIND_TIME) ? n_hour : 7'd0;
            r_om   <= (n_kind == lltx_pkg::KIND_TIME) ? n_min : 7'd0;
            r_os   <= (n_kind == lltx_pkg::KIND_TIME) ? n_sec : 7'd0;
            r_oms  <= n_oms;
        end
        if (!i_rst_n) begin
            r_state  <= lltx_pkg::BS_RUN;
            r_phase  <= lltx_pkg::PH_COPY;
            r_etotal <= '0;  r_ltotal <= '0;  r_qbegin <= '0;
            r_inq    <= 1'b0; r_ovf   <= 1'b0; r_haspay <= 1'b0;
            r_eidx   <= '0;  r_loff   <= '0;  r_tpos   <= '0;
            r_hour   <= '0;  r_min    <= '0;  r_sec    <= '0;  r_milli <= '0;
            r_mode   <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;  r_phase  <= n_phase;
            r_etotal <= n_etotal; r_ltotal <= n_ltotal; r_qbegin <= n_qbegin;
            r_inq    <= n_inq;    r_ovf    <= n_ovf;    r_haspay <= n_haspay;
            r_eidx   <= n_eidx;   r_loff   <= n_loff;   r_tpos   <= n_tpos;
            r_hour   <= n_hour;   r_min    <= n_min;    r_sec    <= n_sec;
            r_milli  <= n_milli;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (take) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // overflow flag goes out with the result of the word that set it
    logic r_ovf_out;
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ovf_out <= n_ovf;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.kind            = r_kind;
    assign o_out.payload         = r_pay;
    assign o_out.hours           = r_oh;
    assign o_out.minutes         = r_om;
    assign o_out.seconds         = r_os;
    assign o_out.millis          = r_oms;
    assign o_out.format_overflow = r_ovf_out;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != lltx_pkg::PH_COPY && r_state == lltx_pkg::BS_RUN) |-> (r_eidx < r_etotal))
        else $error("element index past pattern end");
    a_fetch_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lltx_pkg::BS_REQ_E) |=> (r_state == lltx_pkg::BS_CAP_E))
        else $error("element fetch sequence broken");
    a_tpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tpos <= 4'd11) else $error("time position out of range");
    a_lit_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ltotal <= lltx_pkg::LTOT_W'(lltx_pkg::LITERAL_DEPTH)) else $error("literal total");
`endif
endmodule

// ===== hw/rtl/log_line_timestamp_extractor.sv =====
// result: a result word is registered and offered in the cycle after its input word is taken
// throughput: one word per cycle without back-pressure; a word that moves the line to a new element,
// end of format included, waits in BS_REQ_E and BS_CAP_E for the element store read, and in BS_CAP_L
// too if that element is a literal; a literal step, or a literal mismatch after a partial match, waits in BS_CAP_L
// reset: i_rst_n synchronous active low, clears control state; the element and literal
// stores hold no reset and are only read where written

module log_line_timestamp_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    lltx_in_if.sink    i_in,
    lltx_out_if.source o_out
);
    logic           q_valid;
    logic           q_pop;
    lltx_pkg::t_cmd q_cmd;

    lltx_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    lltx_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (q_valid),
        .i_cmd      (q_cmd),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );
endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for log_line_timestamp_extractor
// needs lltx_pkg, lltx_in_if and lltx_out_if; keeps its own pattern and line model
// and checks every result word against it

module tb_top;
    import lltx_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [7:0] payload;
        logic [6:0] hours;
        logic [6:0] minutes;
        logic [6:0] seconds;
        logic [9:0] millis;
        logic       ovf;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_data;

    lltx_in_if  in_ch ();
    lltx_out_if out_ch ();

    log_line_timestamp_extractor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // model of the pattern and line state
    logic [7:0] pat_ch    [MAX_ELEMENTS];
    int         pat_lo    [MAX_ELEMENTS];
    int         pat_hi    [MAX_ELEMENTS];
    logic [7:0] lit_mem   [LITERAL_DEPTH];
    int         pat_count, lit_count, quote_start;
    bit         in_quote, ovf_seen, has_payload, time_mode;
    t_phase     phase;
    int         elem_idx, lit_off, tpos;
    int         hh_acc, mm_acc, ss_acc, ms_acc;

    t_result    expected_words[$];
    int         errors;
    int         words_sent;
    int         quiet_cycles;
    bit         calm;

    function automatic bit is_skip_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z" && c != CH_T) ||
               (c >= "0" && c <= "9") || c == CH_SPACE;
    endfunction

    function automatic void add_elem(logic [7:0] c, int lo, int hi);
        if (pat_count >= MAX_ELEMENTS) begin
            ovf_seen = 1;
            return;
        end
        pat_ch[pat_count] = c;
        pat_lo[pat_count] = lo;
        pat_hi[pat_count] = hi;
        pat_count++;
    endfunction

    function automatic void close_quote();
        in_quote = 0;
        if (lit_count > quote_start) add_elem(CH_QUOTE, quote_start, lit_count - 1);
    endfunction

    function automatic void enter_elem();
        if (elem_idx >= pat_count) begin
            phase = PH_COPY;
            elem_idx = 0;
            return;
        end
        if (pat_ch[elem_idx] == CH_QUOTE) begin
            phase = PH_LIT;
            lit_off = 0;
        end else if (pat_ch[elem_idx] == CH_T) begin
            phase = PH_TIME;
            tpos = 0;
            hh_acc = 0; mm_acc = 0; ss_acc = 0; ms_acc = 0;
        end else begin
            phase = PH_WAIT;
        end
    endfunction

    // one byte into the time field, 1 when the field completes
    function automatic bit time_step(logic [7:0] c);
        bit dig;
        int d;
        int p;
        dig = c >= "0" && c <= "9";
        d = dig ? int'(c) - 48 : 0;
        p = tpos;
        if (p == 2 || p == 5) begin
            tpos = (c == CH_COLON) ? p + 1 : 0;
            return 0;
        end
        if (p == 8) begin
            tpos = (c == CH_DOT) ? 9 : 0;
            return 0;
        end
        if (p > 11 || !dig) begin
            tpos = 0;
            return 0;
        end
        case (p)
            0: hh_acc = d;
            1: hh_acc = hh_acc * 10 + d;
            3: mm_acc = d;
            4: mm_acc = mm_acc * 10 + d;
            6: ss_acc = d;
            7: begin
                ss_acc = ss_acc * 10 + d;
                tpos = 8;
                return time_mode == 0;
            end
            9: ms_acc = d;
            10: ms_acc = ms_acc * 10 + d;
            default: begin
                ms_acc = ms_acc * 10 + d;
                tpos = 0;
                return 1;
            end
        endcase
        tpos = p + 1;
        return 0;
    endfunction

    function automatic t_result predict_word(t_action a, logic [7:0] c);
        t_result r;
        int at;
        r = '{KIND_NONE, 8'd0, 7'd0, 7'd0, 7'd0, 10'd0, 1'b0};
        if (a == ACT_CLEAR) begin
            pat_count = 0; lit_count = 0; quote_start = 0;
            in_quote = 0; ovf_seen = 0;
            phase = PH_COPY; elem_idx = 0; has_payload = 0;
        end else if (a == ACT_FMT) begin
            if (in_quote) begin
                if (c == CH_QUOTE) close_quote();
                else if (lit_count >= LITERAL_DEPTH) ovf_seen = 1;
                else lit_mem[lit_count++] = c;
            end else if (c == CH_QUOTE) begin
                in_quote = 1;
                quote_start = lit_count;
            end else if (!is_skip_char(c)) begin
                add_elem(c, 0, 0);
            end
        end else if (a == ACT_END) begin
            if (in_quote) close_quote();
            elem_idx = 0;
            enter_elem();
            has_payload = 0;
        end else if (c == CH_CR || c == CH_LF) begin
            if (has_payload) r.kind = KIND_EOL;
            has_payload = 0;
            elem_idx = 0;
            enter_elem();
        end else if (phase == PH_COPY) begin
            r.kind = KIND_PAYLOAD;
            r.payload = c;
            has_payload = 1;
        end else if (elem_idx < pat_count) begin
            if (phase == PH_WAIT) begin
                if (c == pat_ch[elem_idx]) begin
                    elem_idx++;
                    enter_elem();
                end
            end else if (phase == PH_LIT) begin
                at = pat_lo[elem_idx] + lit_off;
                if (at < LITERAL_DEPTH && c == lit_mem[at]) begin
                    if (at >= pat_hi[elem_idx]) begin
                        elem_idx++;
                        enter_elem();
                    end else begin
                        lit_off++;
                    end
                end else begin
                    lit_off = 0;
                end
            end else if (time_step(c)) begin
                r.kind = KIND_TIME;
                r.hours = hh_acc[6:0];
                r.minutes = mm_acc[6:0];
                r.seconds = ss_acc[6:0];
                r.millis = time_mode ? ms_acc[9:0] : 10'd0;
                elem_idx++;
                enter_elem();
            end
        end else begin
            elem_idx = 0;
            enter_elem();
        end
        r.ovf = ovf_seen;
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 0;
        in_ch.action = ACT_CLEAR;
        in_ch.char_in = 0;
        out_ch.ready = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        i_rst_n = 0;
    end

    // sink side, random back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word, kind %0d", out_ch.kind);
            end else begin
                e = expected_words.pop_front();
                if (out_ch.kind !== e.kind || out_ch.payload !== e.payload ||
                    out_ch.hours !== e.hours || out_ch.minutes !== e.minutes ||
                    out_ch.seconds !== e.seconds || out_ch.millis !== e.millis ||
                    out_ch.format_overflow !== e.ovf) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp k%0d p%h %0d:%0d:%0d.%0d o%0d, got k%0d p%h %0d:%0d:%0d.%0d o%0d",
                                 e.kind, e.payload, e.hours, e.minutes, e.seconds, e.millis,
                                 e.ovf, out_ch.kind, out_ch.payload, out_ch.hours,
                                 out_ch.minutes, out_ch.seconds, out_ch.millis,
                                 out_ch.format_overflow);
                end
            end
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 2000) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_word(t_action a, logic [7:0] c);
        while (!calm && $urandom_range(99) < 8) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.action <= a;
        in_ch.char_in <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_words.push_back(predict_word(a, c));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_word(ACT_LOG, s[i]);
    endtask

    task automatic send_format(string s);
        send_word(ACT_CLEAR, 8'h00);
        for (int i = 0; i < s.len(); i++) send_word(ACT_FMT, s[i]);
        send_word(ACT_END, 8'h00);
    endtask

    // drain, let the block settle, then write the mode register
    task automatic set_time_mode(bit m);
        in_ch.valid <= 0;
        @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we <= 0;
        time_mode = m;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_CR || b == CH_LF) b = 8'h7e;
        return b;
    endfunction

    function automatic logic [7:0] digit();
        return 8'(48 + $urandom_range(9));
    endfunction

    task automatic test_time_fields();
        send_format("ab 9 \"<\"  T]");
        send_text("xx<12:34:56]payload\n");
        send_text("<00:00:00]\r<99:99:99]z\n");
        send_text("<1a:23:45]<12;34:56]<12:34:56]\n");
        set_time_mode(1);
        send_text("<23:59:59.999]q\r<01:02:03,004]<01:02:03.004]\n");
        // mode dropped while the field waits for its millisecond part
        send_text("<11:22:33");
        set_time_mode(0);
        send_text(".456]k\n");
        send_format("");
        send_text("plain\r\n");
        send_format("\"open");
        send_text("xxopen-rest\n");
    endtask

    task automatic test_overflow();
        send_word(ACT_CLEAR, 8'h00);
        for (int i = 0; i < MAX_ELEMENTS + 2; i++) send_word(ACT_FMT, "-");
        send_word(ACT_END, 8'h00);
        send_word(ACT_LOG, "-");
        send_word(ACT_CLEAR, 8'h00);
        send_word(ACT_FMT, CH_QUOTE);
        // long run with no idling on either side
        calm = 1;
        for (int i = 0; i < LITERAL_DEPTH + 3; i++) send_word(ACT_FMT, plain_byte() | 8'h01);
        calm = 0;
        send_word(ACT_FMT, CH_QUOTE);
        send_word(ACT_END, 8'h00);
        send_word(ACT_CLEAR, 8'h00);
    endtask

    task automatic random_format();
        int n;
        logic [7:0] c;
        send_word(ACT_CLEAR, 8'h00);
        n = $urandom_range(4);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
                0: send_word(ACT_FMT, CH_T);
                1: begin
                    send_word(ACT_FMT, CH_QUOTE);
                    for (int j = $urandom_range(3); j > 0; j--) begin
                        c = plain_byte();
                        send_word(ACT_FMT, c == CH_QUOTE ? 8'h21 : c);
                    end
                    if (i != n - 1 || $urandom_range(3) != 0) send_word(ACT_FMT, CH_QUOTE);
                end
                2: begin
                    c = 8'($urandom_range(255));
                    if (is_skip_char(c) || c == CH_QUOTE || c == CH_T || c == CH_CR ||
                        c == CH_LF) c = "-";
                    send_word(ACT_FMT, c);
                end
                default: send_word(ACT_FMT, $urandom_range(1) ? "a" : " ");
            endcase
        end
        send_word(ACT_END, 8'h00);
    endtask

    task automatic send_time_text();
        bit broken;
        broken = $urandom_range(9) == 0;
        send_word(ACT_LOG, digit());
        send_word(ACT_LOG, digit());
        send_word(ACT_LOG, broken ? "x" : CH_COLON);
        send_word(ACT_LOG, digit());
        send_word(ACT_LOG, digit());
        send_word(ACT_LOG, CH_COLON);
        send_word(ACT_LOG, digit());
        send_word(ACT_LOG, digit());
        if (time_mode) begin
            send_word(ACT_LOG, CH_DOT);
            repeat (3) send_word(ACT_LOG, digit());
        end
    endtask

    // a line that follows the pattern, with some junk and corruption
    task automatic send_good_line();
        int n;
        n = pat_count;
        for (int i = 0; i < n; i++) begin
            if (pat_ch[i] == CH_T) begin
                send_time_text();
            end else if (pat_ch[i] == CH_QUOTE) begin
                for (int j = pat_lo[i]; j <= pat_hi[i]; j++)
                    send_word(ACT_LOG, $urandom_range(19) == 0 ? plain_byte() : lit_mem[j]);
            end else begin
                for (int j = $urandom_range(2); j > 0; j--) send_word(ACT_LOG, plain_byte());
                send_word(ACT_LOG, pat_ch[i]);
            end
        end
        for (int j = $urandom_range(6); j > 0; j--) send_word(ACT_LOG, plain_byte());
        send_word(ACT_LOG, $urandom_range(1) ? CH_LF : CH_CR);
    endtask

    task automatic send_noise();
        int r;
        r = $urandom_range(99);
        if (r < 3) send_word(ACT_CLEAR, 8'($urandom_range(255)));
        else if (r < 8) send_word(ACT_END, 8'($urandom_range(255)));
        else if (r < 20) send_word(ACT_FMT, 8'($urandom_range(255)));
        else send_word(ACT_LOG, 8'($urandom_range(255)));
    endtask

    task automatic test_random_lines();
        int goal;
        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 4);
            if (ph % 3 == 1) set_time_mode(1'($urandom_range(1)));
            random_format();
            goal = words_sent + 10;
            while (words_sent < goal) begin
                if ($urandom_range(99) < 15) send_noise();
                else send_good_line();
            end
        end
        calm = 0;
    endtask

    initial begin
        errors = 0;
        words_sent = 0;
        calm = 0;
        pat_count = 0; lit_count = 0; quote_start = 0;
        in_quote = 0; ovf_seen = 0; has_payload = 0; time_mode = 0;
        phase = PH_COPY; elem_idx = 0; lit_off = 0; tpos = 0;
        hh_acc = 0; mm_acc = 0; ss_acc = 0; ms_acc = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        test_time_fields();
        test_overflow();
        test_random_lines();
        set_time_mode(1);
        set_time_mode(0);
        in_ch.valid <= 0;
        @(negedge i_clk);
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
